### design/pmpr_pkg.sv
// shared constants, codes and types of the position move power ramp unit
package pmpr_pkg;

  localparam int POS_W      = 32;
  localparam int PWR_W      = 8;
  localparam int DIST_W     = 16;
  localparam int DRV_W      = 9;
  localparam int ACT_W      = 3;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam int DIGIT_W = 4;
  localparam int OP_W    = 36;
  localparam int NIBBLES = OP_W / DIGIT_W;
  localparam int CNT_W   = $clog2(NIBBLES);
  localparam int PROD_W  = DIST_W + PWR_W;

  localparam logic [ACT_W-1:0] ACT_SET    = 3'd0;
  localparam logic [ACT_W-1:0] ACT_TICK   = 3'd1;
  localparam logic [ACT_W-1:0] ACT_INC    = 3'd2;
  localparam logic [ACT_W-1:0] ACT_DEC    = 3'd3;
  localparam logic [ACT_W-1:0] ACT_RESUME = 3'd4;

  localparam logic [CFG_IDX_W-1:0] CFG_FULL_POWER     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LONG_SLOWDOWN  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SHORT_SLOWDOWN = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_TOLERANCE      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_SLOW_POWER = 3'd4;

  localparam logic [PWR_W-1:0]  FULL_POWER_RST     = 8'd255;
  localparam logic [DIST_W-1:0] LONG_SLOWDOWN_RST  = 16'd400;
  localparam logic [DIST_W-1:0] SHORT_SLOWDOWN_RST = 16'd100;
  localparam logic [DIST_W-1:0] TOLERANCE_RST      = 16'd5;
  localparam logic [PWR_W-1:0]  MIN_SLOW_POWER_RST = 8'd60;
  localparam logic [PWR_W-1:0]  PWR_MAX            = 8'd255;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ADD,
    ST_EVAL,
    ST_MAP,
    ST_PUSH
  } state_t;

  typedef struct packed {
    logic load;
    logic shift;
    logic sub;
  } as_ctl_t;

endpackage

### design/position_move_power_ramp_unit.sv
// top level of the point to point move controller with linear slowdown
//
//   port group   direction   handshake           payload
//   in_*         in          in_valid/in_ready   action, position, amount, motor_level
//   out_*        out         out_valid/out_ready drive, drive_valid, done_res
//   cfg_*        in          cfg_we              cfg_index, cfg_data
//
// each request runs from accept through the nine nibble passes of the serial
// subtractor, one evaluate and one push state into the result register;
// the next request is taken in the idle state that follows the push. a tick inside
// the slowdown distance adds the 8 step multiply, 8 step divide and the ramp capture.
// synchronous active low reset restores register defaults and move state.
// a new request is taken while a result still waits in the output register;
// a stalled output holds the next result until the register frees.
module position_move_power_ramp_unit (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic [pmpr_pkg::ACT_W-1:0]            in_action,
  input  logic signed [pmpr_pkg::POS_W-1:0]     in_position,
  input  logic signed [pmpr_pkg::POS_W-1:0]     in_amount,
  input  logic [pmpr_pkg::PWR_W-1:0]            in_motor_level,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic signed [pmpr_pkg::DRV_W-1:0]     out_drive,
  output logic                                  out_drive_valid,
  output logic                                  out_done_res,
  input  logic                                  cfg_we,
  input  logic [pmpr_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [pmpr_pkg::CFG_DATA_W-1:0]       cfg_data
);

  localparam int OW  = pmpr_pkg::OP_W;
  localparam int PW  = pmpr_pkg::PWR_W;
  localparam int DW  = pmpr_pkg::DIST_W;
  localparam int XW  = pmpr_pkg::POS_W;
  localparam int VW  = pmpr_pkg::DRV_W;
  localparam int CW  = pmpr_pkg::CNT_W;
  localparam logic [CW-1:0] LAST_NIB = CW'(pmpr_pkg::NIBBLES - 1);

  pmpr_pkg::state_t  state_r;
  pmpr_pkg::state_t  state_nxt;
  pmpr_pkg::as_ctl_t as_ctl;

  logic [CW-1:0]        cnt_r;
  logic [pmpr_pkg::ACT_W-1:0] act_r;
  logic signed [XW-1:0] goal_r;
  logic [DW-1:0]        slow_r;
  logic [PW-1:0]        ceil_r;
  logic [PW-1:0]        full_power_r;
  logic [DW-1:0]        long_slow_r;
  logic [DW-1:0]        short_slow_r;
  logic [DW-1:0]        tol_r;
  logic [PW-1:0]        min_pwr_r;
  logic                 neg_r;
  logic                 span_neg_r;
  logic [VW-1:0]        res_drive_r;
  logic                 res_dv_r;
  logic                 res_done_r;
  logic                 out_valid_r;
  logic [VW-1:0]        out_drive_r;
  logic                 out_dv_r;
  logic                 out_done_r;

  logic [OW-1:0] op_a;
  logic [OW-1:0] op_b;
  logic          op_sub;
  logic [OW-1:0] fwd;
  logic [OW-1:0] rev;
  logic          accept;
  logic          push;
  logic          map_go;
  logic          md_start;
  logic          md_busy;
  logic [PW-1:0] md_quot;

  logic          neg;
  logic [OW-1:0] dist_abs;
  logic          dist_small;
  logic          le_tol;
  logic          le_long;
  logic          le_slow;
  logic [PW:0]   span;
  logic          span_neg;
  logic [PW-1:0] span_mag;
  logic          v_neg;
  logic          v_hi;
  logic [PW-1:0] inc_ceil;
  logic [PW-1:0] dec_ceil;
  logic [VW-1:0] ceil_drive;
  logic [PW+1:0] ramp_sum;
  logic [PW-1:0] ramp_mag;
  logic [VW-1:0] ramp_drive;

  // operand selection at accept
  always_comb begin
    op_a   = '0;
    op_b   = '0;
    op_sub = 1'b1;
    case (in_action) inside
      pmpr_pkg::ACT_TICK: begin
        op_a = {{(OW-XW){in_position[XW-1]}}, in_position};
        op_b = {{(OW-XW){goal_r[XW-1]}}, goal_r};
      end
      pmpr_pkg::ACT_SET: begin
        op_a = {{(OW-XW){in_amount[XW-1]}}, in_amount};
        op_b = {{(OW-XW){in_position[XW-1]}}, in_position};
      end
      pmpr_pkg::ACT_INC, pmpr_pkg::ACT_DEC: begin
        op_a   = {{(OW-PW){1'b0}}, in_motor_level};
        op_b   = {{(OW-XW){in_amount[XW-1]}}, in_amount};
        op_sub = (in_action == pmpr_pkg::ACT_DEC);
      end
      default: begin
        op_a = '0;
      end
    endcase
  end

  pmpr_addsub u_addsub (
    .clk  (clk),
    .ctl  (as_ctl),
    .a_in (op_a),
    .b_in (op_b),
    .fwd  (fwd),
    .rev  (rev)
  );

  // distance, compares and ceiling updates
  always_comb begin
    neg        = fwd[OW-1];
    dist_abs   = neg ? rev : fwd;
    dist_small = ~|dist_abs[OW-1:DW];
    le_tol     = dist_small && (dist_abs[DW-1:0] <= tol_r);
    le_long    = dist_small && (dist_abs[DW-1:0] <= long_slow_r);
    le_slow    = dist_small && (dist_abs[DW-1:0] <= slow_r);
    span       = {1'b0, ceil_r} - {1'b0, min_pwr_r};
    span_neg   = span[PW];
    span_mag   = span_neg ? (~span[PW-1:0] + 1'b1) : span[PW-1:0];
    v_neg      = fwd[OW-1];
    v_hi       = |fwd[OW-1:PW];
    inc_ceil   = v_neg ? '0 : (v_hi ? pmpr_pkg::PWR_MAX : fwd[PW-1:0]);
    if (v_neg || (!v_hi && (fwd[PW-1:0] < min_pwr_r))) begin
      dec_ceil = min_pwr_r;
    end else begin
      dec_ceil = v_hi ? pmpr_pkg::PWR_MAX : fwd[PW-1:0];
    end
    ceil_drive = neg ? {1'b0, ceil_r} : (~{1'b0, ceil_r} + 1'b1);
    map_go     = (act_r == pmpr_pkg::ACT_TICK) && !le_tol && le_slow
              && (slow_r != '0);
  end

  // ramp magnitude from the quotient
  always_comb begin
    ramp_sum   = {2'b00, min_pwr_r}
               + (span_neg_r ? (~{2'b00, md_quot} + 1'b1) : {2'b00, md_quot});
    ramp_mag   = ramp_sum[PW-1:0];
    ramp_drive = neg_r ? {1'b0, ramp_mag} : (~{1'b0, ramp_mag} + 1'b1);
  end

  pmpr_muldiv u_muldiv (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (md_start),
    .dist_abs (dist_abs[DW-1:0]),
    .divisor  (slow_r),
    .span_mag (span_mag),
    .busy     (md_busy),
    .quot     (md_quot)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      pmpr_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_nxt = pmpr_pkg::ST_ADD;
        end
      end
      pmpr_pkg::ST_ADD: begin
        if (cnt_r == LAST_NIB) begin
          state_nxt = pmpr_pkg::ST_EVAL;
        end
      end
      pmpr_pkg::ST_EVAL: begin
        state_nxt = map_go ? pmpr_pkg::ST_MAP : pmpr_pkg::ST_PUSH;
      end
      pmpr_pkg::ST_MAP: begin
        if (!md_busy) begin
          state_nxt = pmpr_pkg::ST_PUSH;
        end
      end
      pmpr_pkg::ST_PUSH: begin
        if (!out_valid_r || out_ready) begin
          state_nxt = pmpr_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = pmpr_pkg::ST_IDLE;
      end
    endcase
  end

  // control outputs
  always_comb begin
    in_ready     = 1'b0;
    as_ctl.load  = 1'b0;
    as_ctl.shift = 1'b0;
    as_ctl.sub   = op_sub;
    md_start     = 1'b0;
    push         = 1'b0;
    unique case (state_r)
      pmpr_pkg::ST_IDLE: begin
        in_ready    = 1'b1;
        as_ctl.load = in_valid;
      end
      pmpr_pkg::ST_ADD: begin
        as_ctl.shift = 1'b1;
      end
      pmpr_pkg::ST_EVAL: begin
        md_start = map_go;
      end
      pmpr_pkg::ST_MAP: begin
        md_start = 1'b0;
      end
      pmpr_pkg::ST_PUSH: begin
        push = !out_valid_r || out_ready;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  assign accept = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= pmpr_pkg::ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      if (accept) begin
        cnt_r <= '0;
      end else if (state_r == pmpr_pkg::ST_ADD) begin
        cnt_r <= cnt_r + 1'b1;
      end
    end
  end

  // configuration and move state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      full_power_r <= pmpr_pkg::FULL_POWER_RST;
      long_slow_r  <= pmpr_pkg::LONG_SLOWDOWN_RST;
      short_slow_r <= pmpr_pkg::SHORT_SLOWDOWN_RST;
      tol_r        <= pmpr_pkg::TOLERANCE_RST;
      min_pwr_r    <= pmpr_pkg::MIN_SLOW_POWER_RST;
      goal_r       <= '0;
      slow_r       <= pmpr_pkg::LONG_SLOWDOWN_RST;
      ceil_r       <= pmpr_pkg::FULL_POWER_RST;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          pmpr_pkg::CFG_FULL_POWER:     full_power_r <= cfg_data[PW-1:0];
          pmpr_pkg::CFG_LONG_SLOWDOWN:  long_slow_r  <= cfg_data[DW-1:0];
          pmpr_pkg::CFG_SHORT_SLOWDOWN: short_slow_r <= cfg_data[DW-1:0];
          pmpr_pkg::CFG_TOLERANCE:      tol_r        <= cfg_data[DW-1:0];
          pmpr_pkg::CFG_MIN_SLOW_POWER: min_pwr_r    <= cfg_data[PW-1:0];
          default: begin
          end
        endcase
      end
      if (accept && (in_action == pmpr_pkg::ACT_SET)) begin
        goal_r <= in_amount;
      end
      if (state_r == pmpr_pkg::ST_EVAL) begin
        case (act_r)
          pmpr_pkg::ACT_SET: begin
            slow_r <= le_long ? short_slow_r : long_slow_r;
            ceil_r <= full_power_r;
          end
          pmpr_pkg::ACT_INC:    ceil_r <= inc_ceil;
          pmpr_pkg::ACT_DEC:    ceil_r <= dec_ceil;
          pmpr_pkg::ACT_RESUME: ceil_r <= full_power_r;
          default: begin
          end
        endcase
      end
    end
  end

  // request result
  always_ff @(posedge clk) begin
    if (accept) begin
      act_r <= in_action;
    end
    if (state_r == pmpr_pkg::ST_EVAL) begin
      neg_r       <= neg;
      span_neg_r  <= span_neg;
      res_drive_r <= ((act_r == pmpr_pkg::ACT_TICK) && !le_tol && !map_go)
                   ? ceil_drive : '0;
      res_dv_r    <= (act_r == pmpr_pkg::ACT_TICK);
      res_done_r  <= ((act_r == pmpr_pkg::ACT_SET) || (act_r == pmpr_pkg::ACT_TICK))
                   && le_tol;
    end else if ((state_r == pmpr_pkg::ST_MAP) && !md_busy) begin
      res_drive_r <= ramp_drive;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (push) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      out_drive_r <= res_drive_r;
      out_dv_r    <= res_dv_r;
      out_done_r  <= res_done_r;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_drive       = out_drive_r;
  assign out_drive_valid = out_dv_r;
  assign out_done_res    = out_done_r;

`ifndef SYNTHESIS
  a_accept_starts_pass: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (state_r == pmpr_pkg::ST_ADD))
    else $error("accepted request did not start the serial pass");

  a_divider_only_in_map: assert property (@(posedge clk) disable iff (!rst_n)
    md_busy |-> (state_r == pmpr_pkg::ST_MAP))
    else $error("multiply/divide unit busy outside the ramp state");

  a_drive_only_on_tick: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_drive != '0)) |-> (out_drive_valid && !out_done_res))
    else $error("nonzero drive on a result that is not an active tick");

  a_push_frees_core: assert property (@(posedge clk) disable iff (!rst_n)
    push |=> (out_valid && (state_r == pmpr_pkg::ST_IDLE)))
    else $error("result push did not return the core to idle");
`endif

endmodule

### design/pmpr_addsub.sv
// nibble serial adder/subtractor giving a op b and b - a in one pass
module pmpr_addsub (
  input  logic                      clk,
  input  pmpr_pkg::as_ctl_t         ctl,
  input  logic [pmpr_pkg::OP_W-1:0] a_in,
  input  logic [pmpr_pkg::OP_W-1:0] b_in,
  output logic [pmpr_pkg::OP_W-1:0] fwd,
  output logic [pmpr_pkg::OP_W-1:0] rev
);

  localparam int DW = pmpr_pkg::DIGIT_W;
  localparam int OW = pmpr_pkg::OP_W;

  logic [OW-1:0] a_r;
  logic [OW-1:0] b_r;
  logic [OW-1:0] fwd_r;
  logic [OW-1:0] rev_r;
  logic          c_fwd_r;
  logic          c_rev_r;
  logic          sub_r;
  logic [DW-1:0] b_dig;
  logic [DW:0]   s_fwd;
  logic [DW:0]   s_rev;

  always_comb begin
    b_dig = sub_r ? ~b_r[DW-1:0] : b_r[DW-1:0];
    s_fwd = {1'b0, a_r[DW-1:0]} + {1'b0, b_dig} + {{DW{1'b0}}, c_fwd_r};
    s_rev = {1'b0, b_r[DW-1:0]} + {1'b0, ~a_r[DW-1:0]} + {{DW{1'b0}}, c_rev_r};
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      a_r     <= a_in;
      b_r     <= b_in;
      sub_r   <= ctl.sub;
      c_fwd_r <= ctl.sub;
      c_rev_r <= 1'b1;
    end else if (ctl.shift) begin
      a_r     <= {{DW{1'b0}}, a_r[OW-1:DW]};
      b_r     <= {{DW{1'b0}}, b_r[OW-1:DW]};
      fwd_r   <= {s_fwd[DW-1:0], fwd_r[OW-1:DW]};
      rev_r   <= {s_rev[DW-1:0], rev_r[OW-1:DW]};
      c_fwd_r <= s_fwd[DW];
      c_rev_r <= s_rev[DW];
    end
  end

  assign fwd = fwd_r;
  assign rev = rev_r;

endmodule

### design/pmpr_muldiv.sv
// shift-add multiply then restoring divide for the slowdown ramp
module pmpr_muldiv (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [pmpr_pkg::DIST_W-1:0] dist_abs,
  input  logic [pmpr_pkg::DIST_W-1:0] divisor,
  input  logic [pmpr_pkg::PWR_W-1:0]  span_mag,
  output logic                        busy,
  output logic [pmpr_pkg::PWR_W-1:0]  quot
);

  localparam int DW     = pmpr_pkg::DIST_W;
  localparam int PW     = pmpr_pkg::PWR_W;
  localparam int QW     = pmpr_pkg::PROD_W;
  localparam int STEP_W = $clog2(PW);
  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(PW - 1);

  logic              busy_r;
  logic              div_phase_r;
  logic [STEP_W-1:0] step_r;
  logic [DW-1:0]     mcand_r;
  logic [DW-1:0]     dvsr_r;
  logic [DW-1:0]     rem_r;
  logic [PW-1:0]     mplr_r;
  logic [PW-1:0]     low_r;
  logic [PW-1:0]     quot_r;
  logic [QW-1:0]     prod_r;
  logic [QW-1:0]     prod_nxt;
  logic [DW:0]       trial;
  logic [DW:0]       diff;
  logic              fits;
  logic              last;

  always_comb begin
    prod_nxt = {prod_r[QW-2:0], 1'b0}
             + (mplr_r[PW-1] ? {{PW{1'b0}}, mcand_r} : {QW{1'b0}});
    trial    = {rem_r, low_r[PW-1]};
    diff     = trial - {1'b0, dvsr_r};
    fits     = !diff[DW];
    last     = (step_r == LAST_STEP);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      div_phase_r <= 1'b0;
      step_r      <= '0;
    end else if (start) begin
      busy_r      <= 1'b1;
      div_phase_r <= 1'b0;
      step_r      <= '0;
    end else if (busy_r) begin
      step_r <= step_r + 1'b1;
      if (last) begin
        if (div_phase_r) begin
          busy_r <= 1'b0;
        end
        div_phase_r <= !div_phase_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      mcand_r <= dist_abs;
      dvsr_r  <= divisor;
      mplr_r  <= span_mag;
      prod_r  <= '0;
    end else if (busy_r && !div_phase_r) begin
      mplr_r <= {mplr_r[PW-2:0], 1'b0};
      prod_r <= prod_nxt;
      if (last) begin
        rem_r <= prod_nxt[QW-1:PW];
        low_r <= prod_nxt[PW-1:0];
      end
    end else if (busy_r) begin
      rem_r  <= fits ? diff[DW-1:0] : trial[DW-1:0];
      low_r  <= {low_r[PW-2:0], 1'b0};
      quot_r <= {quot_r[PW-2:0], fits};
    end
  end

  assign busy = busy_r;
  assign quot = quot_r;

endmodule

### tb/tb_position_move_power_ramp_unit.sv
// self-checking testbench for the position move power ramp unit with random stimulus and stalls
`timescale 1ns / 1ps

module tb_position_move_power_ramp_unit;

  localparam int PWR_TOP = pmpr_pkg::PWR_MAX;
  localparam logic [pmpr_pkg::ACT_W-1:0] ACT_SPARE_LO = pmpr_pkg::ACT_RESUME + 1'b1;
  localparam logic [pmpr_pkg::ACT_W-1:0] ACT_SPARE_HI = '1;
  localparam int PHASES = 8;
  localparam int ITEMS_PER_PHASE = 100;
  localparam int SETTLE_CYCLES = 60;

  typedef struct {
    logic [pmpr_pkg::ACT_W-1:0]        action;
    logic signed [pmpr_pkg::POS_W-1:0] position;
    logic signed [pmpr_pkg::POS_W-1:0] amount;
    logic [pmpr_pkg::PWR_W-1:0]        motor_level;
  } move_req_t;

  typedef struct {
    logic signed [pmpr_pkg::DRV_W-1:0] drive;
    logic                              drive_valid;
    logic                              done_res;
  } drive_res_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [pmpr_pkg::ACT_W-1:0] in_action = '0;
  logic signed [pmpr_pkg::POS_W-1:0] in_position = '0;
  logic signed [pmpr_pkg::POS_W-1:0] in_amount = '0;
  logic [pmpr_pkg::PWR_W-1:0] in_motor_level = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [pmpr_pkg::DRV_W-1:0] out_drive;
  logic out_drive_valid;
  logic out_done_res;
  logic cfg_we = 1'b0;
  logic [pmpr_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [pmpr_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  // register copies
  int full_power_r = pmpr_pkg::FULL_POWER_RST;
  int long_slow_r = pmpr_pkg::LONG_SLOWDOWN_RST;
  int short_slow_r = pmpr_pkg::SHORT_SLOWDOWN_RST;
  int tolerance_r = pmpr_pkg::TOLERANCE_RST;
  int min_power_r = pmpr_pkg::MIN_SLOW_POWER_RST;

  // move state
  longint goal_pos = 0;
  int slowdown_now = pmpr_pkg::LONG_SLOWDOWN_RST;
  int ceiling_now = pmpr_pkg::FULL_POWER_RST;

  move_req_t move_reqs[$];
  drive_res_t drive_expect[$];
  move_req_t cur_req;
  int send_gap = 0;
  int stall_left = 0;
  int mismatch_count = 0;
  int reqs_added = 0;
  bit idling_on = 1'b1;

  position_move_power_ramp_unit DUT (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_action      (in_action),
    .in_position    (in_position),
    .in_amount      (in_amount),
    .in_motor_level (in_motor_level),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_drive      (out_drive),
    .out_drive_valid(out_drive_valid),
    .out_done_res   (out_done_res),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  always #2 clk = ~clk;

  function automatic longint span_between(longint a, longint b);
    return (a > b) ? a - b : b - a;
  endfunction

  function automatic drive_res_t predict_ramp(move_req_t r);
    drive_res_t res;
    longint pos, amt, lvl, dist_abs, mag, v;
    res.drive = '0;
    res.drive_valid = 1'b0;
    res.done_res = 1'b0;
    pos = r.position;
    amt = r.amount;
    lvl = r.motor_level;
    case (r.action)
      pmpr_pkg::ACT_SET: begin
        goal_pos = amt;
        dist_abs = span_between(amt, pos);
        slowdown_now = (dist_abs <= long_slow_r) ? short_slow_r : long_slow_r;
        ceiling_now = full_power_r;
        res.done_res = (dist_abs <= tolerance_r);
      end
      pmpr_pkg::ACT_TICK: begin
        dist_abs = span_between(pos, goal_pos);
        res.drive_valid = 1'b1;
        if (dist_abs <= tolerance_r) begin
          res.done_res = 1'b1;
        end else begin
          if (dist_abs > slowdown_now || slowdown_now == 0)
            mag = ceiling_now;
          else
            mag = min_power_r
                + (dist_abs * (ceiling_now - min_power_r)) / slowdown_now;
          res.drive = (pos < goal_pos) ? mag : -mag;
        end
      end
      pmpr_pkg::ACT_INC: begin
        v = lvl + amt;
        if (v > PWR_TOP) v = PWR_TOP;
        if (v < 0) v = 0;
        ceiling_now = v;
      end
      pmpr_pkg::ACT_DEC: begin
        v = lvl - amt;
        if (v < min_power_r) v = min_power_r;
        if (v > PWR_TOP) v = PWR_TOP;
        if (v < 0) v = 0;
        ceiling_now = v;
      end
      pmpr_pkg::ACT_RESUME: ceiling_now = full_power_r;
      default: ;
    endcase
    return res;
  endfunction

  task automatic push_req(input logic [pmpr_pkg::ACT_W-1:0] act,
                          input logic signed [pmpr_pkg::POS_W-1:0] pos,
                          input logic signed [pmpr_pkg::POS_W-1:0] amt,
                          input logic [pmpr_pkg::PWR_W-1:0] lvl);
    move_req_t r;
    r.action = act;
    r.position = pos;
    r.amount = amt;
    r.motor_level = lvl;
    move_reqs.push_back(r);
    if (act <= pmpr_pkg::ACT_RESUME) reqs_added++;
  endtask

  task automatic write_reg(input logic [pmpr_pkg::CFG_IDX_W-1:0] idx, input int val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val[pmpr_pkg::CFG_DATA_W-1:0];
    case (idx)
      pmpr_pkg::CFG_FULL_POWER:     full_power_r = val;
      pmpr_pkg::CFG_LONG_SLOWDOWN:  long_slow_r = val;
      pmpr_pkg::CFG_SHORT_SLOWDOWN: short_slow_r = val;
      pmpr_pkg::CFG_TOLERANCE:      tolerance_r = val;
      pmpr_pkg::CFG_MIN_SLOW_POWER: min_power_r = val;
      default: ;
    endcase
  endtask

  task automatic wait_drained();
    do @(negedge clk);
    while (move_reqs.size() != 0 || in_valid || drive_expect.size() != 0);
  endtask

  task automatic flag_error(input string msg);
    if (mismatch_count < 10) $display("%0t %s", $time, msg);
    mismatch_count++;
  endtask

  function automatic int pick_setting(int lo, int hi);
    case ($urandom_range(0, 3))
      0: return lo;
      1: return hi;
      default: return $urandom_range(hi, lo);
    endcase
  endfunction

  function automatic longint near_offset();
    longint m;
    case ($urandom_range(0, 5))
      0: m = $urandom_range(0, tolerance_r + 1);
      1: m = tolerance_r + $urandom_range(0, 1);
      2: m = $urandom_range(0, short_slow_r + 2);
      3: m = $urandom_range(0, long_slow_r + 2);
      4: m = $urandom_range(0, 1 << 20);
      default: m = $urandom;
    endcase
    if ($urandom_range(0, 1)) m = -m;
    return m;
  endfunction

  function automatic logic signed [pmpr_pkg::POS_W-1:0] pick_goal();
    case ($urandom_range(0, 7))
      0: return {1'b1, {(pmpr_pkg::POS_W-1){1'b0}}};
      1: return {1'b0, {(pmpr_pkg::POS_W-1){1'b1}}};
      2, 3: return $urandom_range(0, 4000) - 2000;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic signed [pmpr_pkg::POS_W-1:0] pick_step();
    case ($urandom_range(0, 3))
      0: return $urandom_range(0, 300);
      1: return -$urandom_range(0, 300);
      default: return $urandom;
    endcase
  endfunction

  task automatic make_moves(input int n);
    logic signed [pmpr_pkg::POS_W-1:0] goal;
    longint off;
    int target;
    target = reqs_added + n;
    while (reqs_added < target) begin
      case ($urandom_range(0, 9))
        0: push_req($urandom_range(0, 7), $urandom, $urandom, $urandom);
        1: push_req(pmpr_pkg::ACT_INC + $urandom_range(0, 2), $urandom, pick_step(),
                    $urandom);
        2: push_req(pmpr_pkg::ACT_TICK, $urandom, $urandom, $urandom);
        default: begin
          goal = pick_goal();
          off = near_offset();
          push_req(pmpr_pkg::ACT_SET, goal - off, goal, $urandom);
          repeat ($urandom_range(2, 8)) begin
            if ($urandom_range(0, 5) == 0)
              push_req(pmpr_pkg::ACT_INC + $urandom_range(0, 2), $urandom, pick_step(),
                       $urandom);
            push_req(pmpr_pkg::ACT_TICK, goal - off, $urandom, $urandom);
            off = (off * int'($urandom_range(0, 9))) / 10;
          end
        end
      endcase
    end
  endtask

  task automatic check_result();
    drive_res_t want;
    if (drive_expect.size() == 0) begin
      flag_error($sformatf("unexpected result drive %0d valid %0b done %0b",
                           out_drive, out_drive_valid, out_done_res));
    end else begin
      want = drive_expect.pop_front();
      if (want.drive !== out_drive || want.drive_valid !== out_drive_valid ||
          want.done_res !== out_done_res)
        flag_error($sformatf("expected drive %0d valid %0b done %0b, got drive %0d valid %0b done %0b",
                             want.drive, want.drive_valid, want.done_res,
                             out_drive, out_drive_valid, out_done_res));
    end
  endtask

  // request driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      send_gap <= 0;
    end else begin
      if (in_valid && in_ready)
        drive_expect.push_back(predict_ramp(cur_req));
      if (!in_valid || in_ready) begin
        if (send_gap > 0) begin
          send_gap <= send_gap - 1;
          in_valid <= 1'b0;
        end else if (move_reqs.size() != 0 && idling_on && $urandom_range(0, 9) == 0) begin
          send_gap <= $urandom_range(0, 12);
          in_valid <= 1'b0;
        end else if (move_reqs.size() != 0) begin
          cur_req = move_reqs.pop_front();
          in_valid <= 1'b1;
          in_action <= cur_req.action;
          in_position <= cur_req.position;
          in_amount <= cur_req.amount;
          in_motor_level <= cur_req.motor_level;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      stall_left <= 0;
    end else begin
      if (out_valid && out_ready)
        check_result();
      if (stall_left > 0) begin
        stall_left <= stall_left - 1;
        out_ready <= 1'b0;
      end else if (idling_on && $urandom_range(0, 9) == 0) begin
        stall_left <= $urandom_range(0, 12);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  initial begin
    push_req(pmpr_pkg::ACT_SET, 0, 0, 0);
    push_req(pmpr_pkg::ACT_TICK, 0, 0, 0);
    push_req(pmpr_pkg::ACT_TICK, 5, 0, 0);
    push_req(pmpr_pkg::ACT_TICK, -6, 0, 0);
    push_req(pmpr_pkg::ACT_TICK, 100, 0, 0);
    push_req(pmpr_pkg::ACT_TICK, 101, 0, 0);
    push_req(pmpr_pkg::ACT_SET, 32'sh8000_0000, 32'sh7fff_ffff, 8'hff);
    push_req(pmpr_pkg::ACT_TICK, 32'sh8000_0000, -1, 8'hff);
    push_req(pmpr_pkg::ACT_TICK, 32'sh7fff_fe6f, 0, 0);
    push_req(pmpr_pkg::ACT_INC, 0, 32'sh7fff_ffff, 8'hff);
    push_req(pmpr_pkg::ACT_INC, 0, 32'sh8000_0000, 0);
    push_req(pmpr_pkg::ACT_TICK, 32'sh7fff_ff00, 0, 0);
    push_req(pmpr_pkg::ACT_DEC, 0, 32'sh7fff_ffff, 0);
    push_req(pmpr_pkg::ACT_DEC, 0, 32'sh8000_0000, 8'hff);
    push_req(pmpr_pkg::ACT_DEC, 0, 10, 100);
    push_req(pmpr_pkg::ACT_RESUME, '1, '1, '1);
    push_req(pmpr_pkg::ACT_SET, 32'sh7fff_ffff, 32'sh8000_0000, 0);
    push_req(pmpr_pkg::ACT_TICK, 0, 0, 0);
    push_req(ACT_SPARE_LO, $urandom, $urandom, $urandom);
    push_req(ACT_SPARE_HI, '1, '1, '1);
    push_req(pmpr_pkg::ACT_SET, 600, 1000, 0);
    push_req(pmpr_pkg::ACT_TICK, 700, 0, 0);
    push_req(pmpr_pkg::ACT_SET, 599, 1000, 0);
    push_req(pmpr_pkg::ACT_TICK, 999, 0, 0);
    push_req(pmpr_pkg::ACT_TICK, 1200, 0, 0);
    make_moves(ITEMS_PER_PHASE);
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    for (int ph = 1; ph < PHASES; ph++) begin
      wait_drained();
      repeat (40) @(posedge clk);
      idling_on = (ph != 3) && (ph != PHASES - 1);
      case (ph)
        1: begin
          write_reg(pmpr_pkg::CFG_FULL_POWER, 255);
          write_reg(pmpr_pkg::CFG_LONG_SLOWDOWN, 65535);
          write_reg(pmpr_pkg::CFG_SHORT_SLOWDOWN, 1);
          write_reg(pmpr_pkg::CFG_TOLERANCE, 0);
          write_reg(pmpr_pkg::CFG_MIN_SLOW_POWER, 0);
        end
        2: begin
          write_reg(pmpr_pkg::CFG_FULL_POWER, 0);
          write_reg(pmpr_pkg::CFG_LONG_SLOWDOWN, 1);
          write_reg(pmpr_pkg::CFG_SHORT_SLOWDOWN, 65535);
          write_reg(pmpr_pkg::CFG_TOLERANCE, 65535);
          write_reg(pmpr_pkg::CFG_MIN_SLOW_POWER, 255);
        end
        default: begin
          write_reg(pmpr_pkg::CFG_FULL_POWER, pick_setting(0, 255));
          write_reg(pmpr_pkg::CFG_LONG_SLOWDOWN, pick_setting(1, 65535));
          write_reg(pmpr_pkg::CFG_SHORT_SLOWDOWN, pick_setting(1, 65535));
          write_reg(pmpr_pkg::CFG_TOLERANCE, pick_setting(0, 65535));
          write_reg(pmpr_pkg::CFG_MIN_SLOW_POWER, pick_setting(0, 255));
        end
      endcase
      @(posedge clk);
      cfg_we <= 1'b0;
      @(negedge clk);
      make_moves(ITEMS_PER_PHASE);
    end
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0)
      $display("position_move_power_ramp_unit: match");
    else
      $display("position_move_power_ramp_unit: mismatch");
    $finish;
  end

  initial begin
    #2_000_000;
    $display("position_move_power_ramp_unit: mismatch");
    $finish;
  end

endmodule

### filelist.f
design/pmpr_pkg.sv
design/pmpr_addsub.sv
design/pmpr_muldiv.sv
design/position_move_power_ramp_unit.sv
tb/tb_position_move_power_ramp_unit.sv
